/* hw/rtl/thm_pkg.sv */
// thm_pkg: shared widths, codes and types for the timer min-heap.
// Used by thm_mem, thm_seq and timer_min_heap.
`timescale 1ns / 1ps

package thm_pkg;

    localparam int TIME_W       = 48;
    localparam int DELAY_W      = 31;
    localparam int HANDLE_W     = 16;
    localparam int POS_W        = 6;
    localparam int MODE_W       = 2;
    localparam int STATUS_W     = 2;
    localparam int CAPACITY_DEF = 64;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD    = 2'd0,
        MODE_POP    = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_IGNORE = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_RANGE = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_UP_RD,
        S_UP_CMP,
        S_PUT,
        S_TAKE_RD,
        S_TAKE_EVAL,
        S_DN_RD,
        S_DN_CMP,
        S_HEAD_RD,
        S_HEAD_EVAL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [TIME_W-1:0]   expiry;
        logic [HANDLE_W-1:0] handle;
    } t_entry;

    typedef struct packed {
        t_status             status;
        logic [HANDLE_W-1:0] handle_out;
        logic                has_next;
        logic [TIME_W-1:0]   next_delay;
    } t_result;

endpackage

/* hw/rtl/timer_min_heap.sv */
// Timer min-heap: add / pop earliest / remove at slot, one result word per input word.
// Each item is decoded, then an add or a take sifts its key up or down one level at a time;
// every item ends in the head read that forms has_next and next_delay (status-only items skip
// the sift). Throughput: one item at a time; the next word is taken in the cycle after the
// result is registered, even while that result waits. Reset (sync, active low) empties the
// heap; memory is not cleared.
`timescale 1ns / 1ps

module timer_min_heap #(
    parameter int CAPACITY = thm_pkg::CAPACITY_DEF,
    parameter int AW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [thm_pkg::MODE_W-1:0]    i_mode,
    input  logic [thm_pkg::TIME_W-1:0]    i_now_time,
    input  logic [thm_pkg::DELAY_W-1:0]   i_delay,
    input  logic [thm_pkg::HANDLE_W-1:0]  i_handle_in,
    input  logic [thm_pkg::POS_W-1:0]     i_position,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [thm_pkg::STATUS_W-1:0]  o_status,
    output logic [thm_pkg::HANDLE_W-1:0]  o_handle_out,
    output logic [CW-1:0]                 o_entry_count,
    output logic                          o_has_next,
    output logic [thm_pkg::TIME_W-1:0]    o_next_delay
);

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    thm_pkg::t_entry  wr_data;
    logic [AW-1:0]    rd_a_addr;
    logic [AW-1:0]    rd_b_addr;
    thm_pkg::t_entry  rd_a_data;
    thm_pkg::t_entry  rd_b_data;

    logic             res_valid;
    logic             res_ready;
    thm_pkg::t_result res;
    logic [CW-1:0]    res_count;

    logic             r_out_valid;
    thm_pkg::t_result r_res;
    logic [CW-1:0]    r_count;

    thm_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_a_addr (rd_a_addr),
        .i_rd_b_addr (rd_b_addr),
        .o_rd_a_data (rd_a_data),
        .o_rd_b_data (rd_b_data)
    );

    thm_seq #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_now_time    (i_now_time),
        .i_delay       (i_delay),
        .i_handle_in   (i_handle_in),
        .i_position    (i_position),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res         (res),
        .o_entry_count (res_count),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_rd_a_addr   (rd_a_addr),
        .o_rd_b_addr   (rd_b_addr),
        .i_rd_a_data   (rd_a_data),
        .i_rd_b_data   (rd_b_data)
    );

    // output word register
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_res   <= res;
            r_count <= res_count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_res.status;
    assign o_handle_out  = r_res.handle_out;
    assign o_entry_count = r_count;
    assign o_has_next    = r_res.has_next;
    assign o_next_delay  = r_res.next_delay;

endmodule

/* hw/rtl/thm_mem.sv */
// thm_mem: heap storage, one write port and two registered read ports.
// Depends on thm_pkg for the entry type.
`timescale 1ns / 1ps

module thm_mem #(
    parameter int DEPTH = thm_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  thm_pkg::t_entry   i_wr_data,
    input  logic [AW-1:0]     i_rd_a_addr,
    input  logic [AW-1:0]     i_rd_b_addr,
    output thm_pkg::t_entry   o_rd_a_data,
    output thm_pkg::t_entry   o_rd_b_data
);

    thm_pkg::t_entry r_mem [DEPTH];
    thm_pkg::t_entry r_rd_a;
    thm_pkg::t_entry r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_a <= r_mem[i_rd_a_addr];
        r_rd_b <= r_mem[i_rd_b_addr];
    end

    assign o_rd_a_data = r_rd_a;
    assign o_rd_b_data = r_rd_b;

endmodule

/* hw/rtl/thm_seq.sv */
// thm_seq: sequencer for add / pop / remove with sift-up and sift-down,
// one memory level per read state and compare state. Depends on thm_pkg, drives thm_mem.
`timescale 1ns / 1ps

module thm_seq #(
    parameter int CAPACITY = thm_pkg::CAPACITY_DEF,
    parameter int AW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [thm_pkg::MODE_W-1:0]    i_mode,
    input  logic [thm_pkg::TIME_W-1:0]    i_now_time,
    input  logic [thm_pkg::DELAY_W-1:0]   i_delay,
    input  logic [thm_pkg::HANDLE_W-1:0]  i_handle_in,
    input  logic [thm_pkg::POS_W-1:0]     i_position,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output thm_pkg::t_result              o_res,
    output logic [CW-1:0]                 o_entry_count,
    output logic                          o_wr_en,
    output logic [AW-1:0]                 o_wr_addr,
    output thm_pkg::t_entry               o_wr_data,
    output logic [AW-1:0]                 o_rd_a_addr,
    output logic [AW-1:0]                 o_rd_b_addr,
    input  thm_pkg::t_entry               i_rd_a_data,
    input  thm_pkg::t_entry               i_rd_b_data
);

    localparam int KW  = AW + 2;
    localparam int PCW = (CW > thm_pkg::POS_W) ? CW : thm_pkg::POS_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    thm_pkg::t_state  r_state, n_state;
    thm_pkg::t_mode   r_mode;
    thm_pkg::t_status r_status, n_status;
    logic [thm_pkg::TIME_W-1:0]   r_now;
    logic [thm_pkg::DELAY_W-1:0]  r_delay;
    logic [thm_pkg::HANDLE_W-1:0] r_hin;
    logic [thm_pkg::POS_W-1:0]    r_pos;
    logic [thm_pkg::TIME_W-1:0]   r_key, n_key;
    logic [thm_pkg::HANDLE_W-1:0] r_hnd, n_hnd;
    logic [thm_pkg::HANDLE_W-1:0] r_hout, n_hout;
    logic [AW-1:0]                r_slot, n_slot;
    logic [CW-1:0]                r_size, n_size;
    logic [thm_pkg::TIME_W-1:0]   r_next, n_next;

    logic                         accept;
    logic [AW-1:0]                parent;
    logic [KW-1:0]                kid;
    logic [KW-1:0]                size_k;
    logic [CW-1:0]                last;
    logic                         kid_over;
    logic                         pick_left;
    thm_pkg::t_entry              child;
    logic [AW-1:0]                child_idx;
    logic                         up_move;
    logic                         dn_move;
    logic                         slot_is_last;
    logic                         take_up;
    logic                         pos_bad;
    logic [thm_pkg::TIME_W:0]     sum;
    logic [thm_pkg::TIME_W-1:0]   expiry_sat;
    thm_pkg::t_entry              key_entry;

    assign accept     = i_in_valid && (r_state == thm_pkg::S_IDLE);
    assign o_in_ready = (r_state == thm_pkg::S_IDLE);

    // heap index arithmetic; parent of slot 0 wraps but is never used
    assign parent    = AW'((r_slot - AW'(1)) >> 1);
    assign kid       = (KW'(r_slot) + KW'(1)) << 1;
    assign size_k    = KW'(r_size);
    assign last      = r_size - CW'(1);
    assign kid_over  = kid > size_k;
    assign pick_left = (kid == size_k) || (i_rd_b_data.expiry > i_rd_a_data.expiry);
    assign child     = pick_left ? i_rd_a_data : i_rd_b_data;
    assign child_idx = pick_left ? AW'(kid - KW'(1)) : AW'(kid);
    assign up_move   = r_key < i_rd_a_data.expiry;
    assign dn_move   = r_key > child.expiry;
    assign slot_is_last = KW'(r_slot) == KW'(last);
    assign take_up   = (r_slot != '0) && (i_rd_a_data.expiry < i_rd_b_data.expiry);
    assign pos_bad   = PCW'(r_pos) >= PCW'(r_size);
    assign key_entry = '{expiry: r_key, handle: r_hnd};

    always_comb begin
        sum        = {1'b0, r_now} + (thm_pkg::TIME_W + 1)'(r_delay);
        expiry_sat = sum[thm_pkg::TIME_W] ? '1 : sum[thm_pkg::TIME_W-1:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            thm_pkg::S_IDLE: begin
                if (accept) n_state = thm_pkg::S_DECODE;
            end
            thm_pkg::S_DECODE: begin
                case (r_mode)
                    thm_pkg::MODE_ADD: begin
                        if (r_size >= CAP_C)      n_state = thm_pkg::S_HEAD_RD;
                        else if (r_size == '0)    n_state = thm_pkg::S_PUT;
                        else                      n_state = thm_pkg::S_UP_RD;
                    end
                    thm_pkg::MODE_POP: begin
                        if (r_size == '0) n_state = thm_pkg::S_HEAD_RD;
                        else              n_state = thm_pkg::S_TAKE_RD;
                    end
                    thm_pkg::MODE_REMOVE: begin
                        if (r_size == '0 || pos_bad) n_state = thm_pkg::S_HEAD_RD;
                        else                         n_state = thm_pkg::S_TAKE_RD;
                    end
                    default: n_state = thm_pkg::S_HEAD_RD;
                endcase
            end
            thm_pkg::S_UP_RD:  n_state = thm_pkg::S_UP_CMP;
            thm_pkg::S_UP_CMP: begin
                if (!up_move)         n_state = thm_pkg::S_HEAD_RD;
                else if (parent == '0) n_state = thm_pkg::S_PUT;
                else                  n_state = thm_pkg::S_UP_RD;
            end
            thm_pkg::S_PUT:     n_state = thm_pkg::S_HEAD_RD;
            thm_pkg::S_TAKE_RD: n_state = thm_pkg::S_TAKE_EVAL;
            thm_pkg::S_TAKE_EVAL: begin
                if (slot_is_last) n_state = thm_pkg::S_HEAD_RD;
                else if (take_up) n_state = thm_pkg::S_UP_RD;
                else              n_state = thm_pkg::S_DN_RD;
            end
            thm_pkg::S_DN_RD: begin
                if (kid_over) n_state = thm_pkg::S_PUT;
                else          n_state = thm_pkg::S_DN_CMP;
            end
            thm_pkg::S_DN_CMP: begin
                if (dn_move) n_state = thm_pkg::S_DN_RD;
                else         n_state = thm_pkg::S_HEAD_RD;
            end
            thm_pkg::S_HEAD_RD: begin
                if (r_size == '0) n_state = thm_pkg::S_DONE;
                else              n_state = thm_pkg::S_HEAD_EVAL;
            end
            thm_pkg::S_HEAD_EVAL: n_state = thm_pkg::S_DONE;
            thm_pkg::S_DONE: begin
                if (i_res_ready) n_state = thm_pkg::S_IDLE;
            end
            default: n_state = thm_pkg::S_IDLE;
        endcase
    end

    // memory control; reads and writes never share a cycle
    always_comb begin
        o_wr_en     = 1'b0;
        o_wr_addr   = r_slot;
        o_wr_data   = key_entry;
        o_rd_a_addr = parent;
        o_rd_b_addr = '0;
        o_res_valid = 1'b0;
        case (r_state)
            thm_pkg::S_UP_CMP: begin
                o_wr_en   = 1'b1;
                o_wr_data = up_move ? i_rd_a_data : key_entry;
            end
            thm_pkg::S_PUT: o_wr_en = 1'b1;
            thm_pkg::S_TAKE_RD: begin
                o_rd_a_addr = AW'(last);
                o_rd_b_addr = (r_mode == thm_pkg::MODE_POP) ? '0 : parent;
            end
            thm_pkg::S_DN_RD: begin
                o_rd_a_addr = AW'(kid - KW'(1));
                o_rd_b_addr = AW'(kid);
            end
            thm_pkg::S_DN_CMP: begin
                o_wr_en   = 1'b1;
                o_wr_data = dn_move ? child : key_entry;
            end
            thm_pkg::S_HEAD_RD: o_rd_a_addr = '0;
            thm_pkg::S_DONE:    o_res_valid = 1'b1;
            default: ;
        endcase
    end

    // datapath next values
    always_comb begin
        n_status = r_status;
        n_key    = r_key;
        n_hnd    = r_hnd;
        n_hout   = r_hout;
        n_slot   = r_slot;
        n_size   = r_size;
        n_next   = r_next;
        case (r_state)
            thm_pkg::S_IDLE: begin
                if (accept) begin
                    n_status = thm_pkg::STAT_OK;
                    n_hout   = '0;
                end
            end
            thm_pkg::S_DECODE: begin
                case (r_mode)
                    thm_pkg::MODE_ADD: begin
                        if (r_size >= CAP_C) begin
                            n_status = thm_pkg::STAT_FULL;
                        end else begin
                            n_key  = expiry_sat;
                            n_hnd  = r_hin;
                            n_slot = AW'(r_size);
                            n_size = r_size + CW'(1);
                        end
                    end
                    thm_pkg::MODE_POP: begin
                        if (r_size == '0) n_status = thm_pkg::STAT_EMPTY;
                        else              n_slot   = '0;
                    end
                    thm_pkg::MODE_REMOVE: begin
                        if (r_size == '0) n_status = thm_pkg::STAT_EMPTY;
                        else if (pos_bad) n_status = thm_pkg::STAT_RANGE;
                        else              n_slot   = AW'(r_pos);
                    end
                    default: ;
                endcase
            end
            thm_pkg::S_UP_CMP: begin
                if (up_move) n_slot = parent;
            end
            thm_pkg::S_TAKE_EVAL: begin
                n_key  = i_rd_a_data.expiry;
                n_hnd  = i_rd_a_data.handle;
                n_size = last;
                if (r_mode == thm_pkg::MODE_POP) n_hout = i_rd_b_data.handle;
            end
            thm_pkg::S_DN_CMP: begin
                if (dn_move) n_slot = child_idx;
            end
            thm_pkg::S_HEAD_RD: begin
                if (r_size == '0) n_next = '0;
            end
            thm_pkg::S_HEAD_EVAL: begin
                n_next = (i_rd_a_data.expiry > r_now) ? (i_rd_a_data.expiry - r_now)
                                                     : thm_pkg::TIME_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= thm_pkg::S_IDLE;
            r_size  <= '0;
        end else begin
            r_state <= n_state;
            r_size  <= n_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= thm_pkg::t_mode'(i_mode);
            r_now   <= i_now_time;
            r_delay <= i_delay;
            r_hin   <= i_handle_in;
            r_pos   <= i_position;
        end
        r_status <= n_status;
        r_key    <= n_key;
        r_hnd    <= n_hnd;
        r_hout   <= n_hout;
        r_slot   <= n_slot;
        r_next   <= n_next;
    end

    assign o_res = '{status:     r_status,
                     handle_out: r_hout,
                     has_next:   (r_size != '0),
                     next_delay: r_next};
    assign o_entry_count = r_size;

endmodule
